### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pat_pkg.sv
// ----------------------------------------------------------------------------
// pat_pkg
// Shared constants and types of the pending acknowledgement table.
// ----------------------------------------------------------------------------
package pat_pkg;

    localparam int MAX_ENTRIES = 100;
    localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [31:0] seq_num;
        logic [31:0] container_id;
        logic [31:0] stamp;
    } rec_t;

    typedef struct packed {
        logic cmp;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } state_t;

endpackage

### hdl/pat_if.sv
// ----------------------------------------------------------------------------
// pat_if
// Request and response channels of the pending acknowledgement table.
// ----------------------------------------------------------------------------
interface pat_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] seq_num;
    logic [31:0] container_id;
    logic [31:0] stamp;

    modport source (output valid, command, seq_num, container_id, stamp, input ready);
    modport sink   (input valid, command, seq_num, container_id, stamp, output ready);
endinterface

interface pat_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [6:0] entry_count;
    logic       overflowed;

    modport source (output valid, status, entry_count, overflowed, input ready);
    modport sink   (input valid, status, entry_count, overflowed, output ready);
endinterface

### hdl/pat_cell.sv
// ----------------------------------------------------------------------------
// pat_cell
// One slot of the table: holds a record, compares its sequence number and
// takes its neighbor's record when a hit lies at or below it.
// ----------------------------------------------------------------------------
module pat_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  pat_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  logic                load,
    input  logic [31:0]         key,
    input  pat_pkg::rec_t       rec_in,
    input  pat_pkg::rec_t       rec_nbr,
    input  logic                hit_in,
    output logic                hit_out,
    output pat_pkg::rec_t       rec_out
);

    pat_pkg::rec_t rec_reg;
    logic          match_reg;
    logic          match_next;

    assign match_next = ctrl.cmp ? (occupied && (rec_reg.seq_num == key)) : match_reg;
    assign hit_out    = hit_in | match_reg;
    assign rec_out    = rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rec_reg <= rec_in;
        end
        else if (ctrl.shift && hit_out)
        begin
            rec_reg <= rec_nbr;
        end
    end

endmodule

### hdl/pending_ack_table.sv
// ----------------------------------------------------------------------------
// pending_ack_table
// Ordered table of records awaiting acknowledgement, built as a row of cells
// that search in parallel and close gaps by shifting toward the head.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | handshake
//  req     | in  | command, seq_num, container_id, stamp     | valid/ready
//  rsp     | out | status, entry_count, overflowed           | valid/ready
//
//  Add, clear and unused codes load the response when taken; remove compares
//  in every cell, then in search does prefix-hit ripple and one shift step.
//  One request in flight; req.ready drops during the shift cycle and while
//  an untaken response holds the output register.
//  Reset clears count, overflow flag and control; records stay undefined.
// ----------------------------------------------------------------------------
module pending_ack_table (
    input  logic           clk,
    input  logic           rst_n,
    pat_req_if.sink        req,
    pat_rsp_if.source      rsp
);

    localparam int N = pat_pkg::MAX_ENTRIES;
    localparam int W = pat_pkg::COUNT_W;

    pat_pkg::state_t     state_reg, state_next;
    logic [W-1:0]        count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [1:0]          rsp_status_reg, rsp_status_next;
    logic [W-1:0]        rsp_count_reg;
    logic                rsp_ovf_reg;
    logic                load_rsp;

    logic                fire;
    logic                add_ok;
    pat_pkg::cell_ctrl_t ctrl;
    pat_pkg::rec_t       rec_new;
    pat_pkg::rec_t       rec   [N];
    pat_pkg::rec_t       nbr   [N];
    logic [N:0]          hit;
    logic [N-1:0]        occ;
    logic [N-1:0]        load;

    assign req.ready = (state_reg == pat_pkg::S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign fire      = req.valid && req.ready;
    assign add_ok    = fire && (req.command == pat_pkg::CMD_ADD)
                       && (count_reg < W'(N));

    assign rec_new.seq_num      = req.seq_num;
    assign rec_new.container_id = req.container_id;
    assign rec_new.stamp        = req.stamp;

    assign ctrl.cmp   = fire && (req.command == pat_pkg::CMD_REMOVE);
    assign ctrl.shift = (state_reg == pat_pkg::S_SEARCH);
    assign hit[0]     = 1'b0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        assign occ[i]  = (count_reg > W'(i));
        assign load[i] = add_ok && (count_reg == W'(i));

        if (i == N - 1)
        begin : g_last
            assign nbr[i] = rec[i];
        end
        else
        begin : g_mid
            assign nbr[i] = rec[i + 1];
        end

        pat_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .occupied (occ[i]),
            .load     (load[i]),
            .key      (req.seq_num),
            .rec_in   (rec_new),
            .rec_nbr  (nbr[i]),
            .hit_in   (hit[i]),
            .hit_out  (hit[i + 1]),
            .rec_out  (rec[i])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        rsp_status_next = pat_pkg::ST_OK;
        load_rsp        = 1'b0;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;

        unique case (state_reg)
            pat_pkg::S_IDLE:
            begin
                if (fire)
                begin
                    unique case (req.command)
                        pat_pkg::CMD_ADD:
                        begin
                            load_rsp = 1'b1;
                            if (add_ok)
                            begin
                                count_next = count_reg + W'(1);
                            end
                            else
                            begin
                                count_next      = '0;
                                ovf_next        = 1'b1;
                                rsp_status_next = pat_pkg::ST_FULL;
                            end
                        end
                        pat_pkg::CMD_REMOVE:
                        begin
                            state_next = pat_pkg::S_SEARCH;
                        end
                        pat_pkg::CMD_CLEAR:
                        begin
                            load_rsp   = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            load_rsp = 1'b1;
                        end
                    endcase
                end
            end
            pat_pkg::S_SEARCH:
            begin
                load_rsp   = 1'b1;
                state_next = pat_pkg::S_IDLE;
                if (hit[N])
                begin
                    count_next = count_reg - W'(1);
                end
                else
                begin
                    rsp_status_next = pat_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
                state_next = pat_pkg::S_IDLE;
            end
        endcase

        if (load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pat_pkg::S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_rsp)
        begin
            rsp_status_reg <= rsp_status_next;
            rsp_count_reg  <= count_next;
            rsp_ovf_reg    <= ovf_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.entry_count = 7'(rsp_count_reg);
    assign rsp.overflowed  = rsp_ovf_reg;

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_bound, count_reg <= W'(N), "record count beyond capacity")
    `ASSERT_NEXT(a_remove_search, ctrl.cmp, state_reg == pat_pkg::S_SEARCH,
        "remove did not enter search")
    `ASSERT_SAME(a_search_busy, state_reg == pat_pkg::S_SEARCH, !req.ready,
        "request taken during shift")
    `ASSERT_NEXT(a_hit_shrinks, ctrl.shift && hit[N],
        count_reg == $past(count_reg) - W'(1), "hit did not drop one record")

endmodule
